// ===== design/kmp_stream_matcher_top_assert.svh =====
// Assertion macros used by the matcher top level.
`ifndef KMP_STREAM_MATCHER_TOP_ASSERT_SVH
`define KMP_STREAM_MATCHER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock outside reset.
`define KMPM_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define KMPM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/kmpm_pkg.sv =====
// Shared types and constants of the streaming pattern matcher.
package kmpm_pkg;

   // Register file holds 32 pattern bytes in four 64-bit words.
   localparam int PatternBytesC = 32;
   localparam int PatternMaxDefaultC = 32;
   localparam int LenWidthC = 6;
   localparam int PosWidthC = 32;
   localparam int CsrDataWidthC = 64;
   localparam int CsrAddrWidthC = 6;
   localparam int RegIdxWidthC = 3;
   localparam int PatternWordsC = 4;

   // Register indexes.
   localparam logic [RegIdxWidthC-1:0] RegLength = 3'd0;
   localparam logic [RegIdxWidthC-1:0] RegWord0  = 3'd1;
   localparam logic [RegIdxWidthC-1:0] RegWord1  = 3'd2;
   localparam logic [RegIdxWidthC-1:0] RegWord2  = 3'd3;
   localparam logic [RegIdxWidthC-1:0] RegWord3  = 3'd4;

   // Response kinds.
   localparam logic EventMatch   = 1'b0;
   localparam logic EventSummary = 1'b1;

   // Configuration seen by the datapath.
   typedef struct packed {
      logic [PatternBytesC-1:0][7:0] pattern;
      logic [LenWidthC-1:0]          active_len;
      logic                          clear;
   } kmpm_cfg_type;

   // One response item.
   typedef struct packed {
      logic                 kind;
      logic [PosWidthC-1:0] start;
      logic                 found;
      logic                 last;
   } kmpm_rsp_type;

endpackage

// ===== design/kmp_stream_matcher_top.sv =====
// Top level of the streaming byte pattern matcher.
// Finds every occurrence, overlapping ones included, of a 1 to PATTERN_MAX byte pattern in a
// text that arrives one byte per request, and reports each match with its zero-based start
// position; the request marked tlast also yields a summary response telling whether any match
// was seen, after which the position restarts at zero. Matching runs in a chain of PATTERN_MAX
// cells, cell k remembering whether pattern bytes 0..k end at the latest byte, so every byte
// is resolved in the cycle it is taken and its responses are offered from the next cycle. A
// byte is taken when the two-entry response queue will be empty after the current cycle: a
// byte with no response, or with one response that is taken at once, lets the next byte
// follow in the next cycle; a byte with both a match and a summary holds the next byte back
// until its second response is taken; a stalled consumer sets the pace. A write to a known
// register restarts the partial match but keeps the position; reset has no clearing pass.
`include "kmp_stream_matcher_top_assert.svh"

module kmp_stream_matcher_top #(
   parameter int PATTERN_MAX = kmpm_pkg::PatternMaxDefaultC
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] text_byte
   input  logic                                req_tlast,   // end_of_text
   // Response stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [39:0]                         rsp_tdata,   // [31:0] match_start, [32] any_found
   output logic                                rsp_tuser,   // [0] event_kind
   output logic                                rsp_tlast,   // last_result
   // Configuration port.
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [kmpm_pkg::CsrAddrWidthC-1:0]  csr_paddr,
   input  logic [kmpm_pkg::CsrDataWidthC-1:0]  csr_pwdata,
   output logic [kmpm_pkg::CsrDataWidthC-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import kmpm_pkg::*;

   localparam int IdxW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   kmpm_cfg_type            cfg;
   logic                    accept;
   logic                    flush;
   logic [PATTERN_MAX-1:0]  hit_next;
   logic [PATTERN_MAX-1:0]  hit_ff;
   logic [LenWidthC-1:0]    len_m1;
   logic                    match_now;
   logic [PosWidthC-1:0]    pos_ff;
   logic [PosWidthC-1:0]    pos_in;
   logic [PosWidthC-1:0]    len_m1_wide;
   logic [PosWidthC-1:0]    start;
   logic                    seen_ff;
   logic                    seen_in;
   kmpm_rsp_type            match_rsp;
   kmpm_rsp_type            sum_rsp;
   kmpm_rsp_type            push0;
   logic [1:0]              push_count;
   logic                    q_ready;
   kmpm_rsp_type            head;

   // Configuration registers.
   kmpm_csr #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg_out     (cfg)
   );

   assign req_tready = q_ready;
   assign accept     = req_tvalid && req_tready;
   assign flush      = cfg.clear || (accept && req_tlast);

   // Chain of match cells, each fed by its left neighbor's state.
   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic prev_hit;
      if (k == 0) begin : g_first
         assign prev_hit = 1'b1;
      end else begin : g_rest
         assign prev_hit = hit_ff[k-1];
      end
      kmpm_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .step         (accept),
         .flush        (flush),
         .text_byte    (req_tdata),
         .pattern_byte (cfg.pattern[k]),
         .prev_hit     (prev_hit),
         .hit_next     (hit_next[k]),
         .hit_out      (hit_ff[k])
      );
   end

   // A match ends here when the cell of the last pattern byte lights.
   assign len_m1    = cfg.active_len - LenWidthC'(1);
   assign match_now = accept && hit_next[IdxW'(len_m1)];

   // Start position of the match, held at zero below the pattern length.
   assign len_m1_wide = {{(PosWidthC-LenWidthC){1'b0}}, len_m1};
   assign start       = (pos_ff >= len_m1_wide) ? (pos_ff - len_m1_wide) : '0;

   // Position and seen flag; the position saturates at its maximum.
   always_comb begin
      pos_in  = pos_ff;
      seen_in = seen_ff;
      if (accept) begin
         if (req_tlast) begin
            pos_in  = '0;
            seen_in = 1'b0;
         end else begin
            if (pos_ff != '1) begin
               pos_in = pos_ff + PosWidthC'(1);
            end
            seen_in = seen_ff || match_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         seen_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         seen_ff <= seen_in;
      end
   end

   // Build the responses of this request: the match first, then the summary.
   always_comb begin
      match_rsp.kind  = EventMatch;
      match_rsp.start = start;
      match_rsp.found = 1'b1;
      match_rsp.last  = !req_tlast;
      sum_rsp.kind    = EventSummary;
      sum_rsp.start   = '0;
      sum_rsp.found   = seen_ff || match_now;
      sum_rsp.last    = 1'b1;
      push0           = match_now ? match_rsp : sum_rsp;
      push_count      = {1'b0, match_now} + {1'b0, req_tlast};
   end

   kmpm_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_en    (accept),
      .push_count (push_count),
      .push0      (push0),
      .push1      (sum_rsp),
      .in_ready   (q_ready),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_data   (head)
   );

   assign rsp_tdata = {7'b0, head.found, head.start};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   // Checks on the matcher's own logic.
   `KMPM_ASSERT_IMPLIES(a_summary_closes, rsp_tvalid && (rsp_tuser == EventSummary), rsp_tlast && (rsp_tdata[31:0] == '0), "summary response must be last and carry no start")
   `KMPM_ASSERT_NEXT(a_end_restarts, accept && req_tlast, (pos_ff == '0) && !seen_ff, "end of text must restart position and seen flag")
   `KMPM_ASSERT_NEXT(a_match_seen, match_now && !req_tlast, seen_ff, "a match must set the seen flag")
   `KMPM_ASSERT_NEXT(a_flush_cells, flush, hit_ff == '0, "restart must clear every match cell")
endmodule

// ===== design/kmpm_cell.sv =====
// One cell of the matcher chain: tracks whether the pattern prefix up to its byte ends here.
module kmpm_cell (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       flush,
   input  logic [7:0] text_byte,
   input  logic [7:0] pattern_byte,
   input  logic       prev_hit,
   output logic       hit_next,
   output logic       hit_out
);
   logic hit_ff;
   logic hit_in;

   // The prefix ending at this byte extends the neighbor's prefix of the previous byte.
   assign hit_next = prev_hit && (text_byte == pattern_byte);

   always_comb begin
      hit_in = hit_ff;
      if (flush) begin
         hit_in = 1'b0;
      end else if (step) begin
         hit_in = hit_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign hit_out = hit_ff;
endmodule

// ===== design/kmpm_csr.sv =====
// Configuration registers: pattern length and pattern words on a simple bus port.
module kmpm_csr #(
   parameter int PATTERN_MAX = kmpm_pkg::PatternMaxDefaultC
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [kmpm_pkg::CsrAddrWidthC-1:0]   csr_paddr,
   input  logic [kmpm_pkg::CsrDataWidthC-1:0]   csr_pwdata,
   output logic [kmpm_pkg::CsrDataWidthC-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output kmpm_pkg::kmpm_cfg_type               cfg_out
);
   import kmpm_pkg::*;

   logic [LenWidthC-1:0]                         len_ff;
   logic [LenWidthC-1:0]                         len_in;
   logic [PatternWordsC-1:0][CsrDataWidthC-1:0]  word_ff;
   logic [PatternWordsC-1:0][CsrDataWidthC-1:0]  word_in;
   logic [RegIdxWidthC-1:0]                      reg_index;
   logic                                         wr;
   logic                                         clear;
   logic [LenWidthC-1:0]                         active_len;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[CsrAddrWidthC-1:3];
   assign wr         = csr_psel && csr_penable && csr_pwrite;

   // Register writes; a write to a known register restarts matching.
   always_comb begin
      len_in  = len_ff;
      word_in = word_ff;
      clear   = 1'b0;
      if (wr) begin
         unique case (reg_index)
            RegLength: begin
               len_in = csr_pwdata[LenWidthC-1:0];
               clear  = 1'b1;
            end
            RegWord0: begin
               word_in[0] = csr_pwdata;
               clear      = 1'b1;
            end
            RegWord1: begin
               word_in[1] = csr_pwdata;
               clear      = 1'b1;
            end
            RegWord2: begin
               word_in[2] = csr_pwdata;
               clear      = 1'b1;
            end
            RegWord3: begin
               word_in[3] = csr_pwdata;
               clear      = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= LenWidthC'(1);
         word_ff <= '0;
      end else begin
         len_ff  <= len_in;
         word_ff <= word_in;
      end
   end

   // Read back.
   always_comb begin
      unique case (reg_index)
         RegLength: csr_prdata = {{(CsrDataWidthC-LenWidthC){1'b0}}, len_ff};
         RegWord0:  csr_prdata = word_ff[0];
         RegWord1:  csr_prdata = word_ff[1];
         RegWord2:  csr_prdata = word_ff[2];
         RegWord3:  csr_prdata = word_ff[3];
         default:   csr_prdata = '0;
      endcase
   end

   // Length in use: zero counts as one, anything above the cell count is clamped.
   always_comb begin
      priority if (len_ff == '0) begin
         active_len = LenWidthC'(1);
      end else if (len_ff > LenWidthC'(PATTERN_MAX)) begin
         active_len = LenWidthC'(PATTERN_MAX);
      end else begin
         active_len = len_ff;
      end
   end

   assign cfg_out.pattern    = word_ff;
   assign cfg_out.active_len = active_len;
   assign cfg_out.clear      = clear;
endmodule

// ===== design/kmpm_rsp_queue.sv =====
// Two-entry response queue that holds the results of one request.
module kmpm_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_en,
   input  logic [1:0]             push_count,
   input  kmpm_pkg::kmpm_rsp_type push0,
   input  kmpm_pkg::kmpm_rsp_type push1,
   output logic                   in_ready,
   input  logic                   out_ready,
   output logic                   out_valid,
   output kmpm_pkg::kmpm_rsp_type out_data
);
   import kmpm_pkg::*;

   logic [1:0]             count_ff;
   logic [1:0]             count_in;
   kmpm_rsp_type [1:0]     q_ff;
   kmpm_rsp_type [1:0]     q_in;
   logic                   pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_data  = q_ff[0];
   assign pop       = out_valid && out_ready;
   // A request is taken only when the queue is empty once this cycle's pop is done.
   assign in_ready  = (count_ff == 2'd0) || ((count_ff == 2'd1) && out_ready);

   always_comb begin
      q_in     = q_ff;
      count_in = count_ff;
      if (pop) begin
         q_in[0]  = q_ff[1];
         count_in = count_ff - 2'd1;
      end
      if (push_en) begin
         q_in[0]  = push0;
         q_in[1]  = push1;
         count_in = push_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end
endmodule
